// ===== design/gfcc_pkg.sv =====
// Shared constants and types for the grid frontier completion check.
package gfcc_pkg;

  localparam int CNT_W = 21;
  localparam int SIZE_W = 13;
  localparam int COST_W = 8;
  localparam int CFG_IDX_W = 2;

  typedef logic [CNT_W-1:0] count_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [COST_W-1:0] cost_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam count_t COUNT_MAX = {CNT_W{1'b1}};
  localparam cost_t COST_UNKNOWN = 8'd255;
  localparam cost_t COST_BLOCKED = 8'd253;

  localparam cfg_idx_t REG_GRID_WIDTH = 2'd0;
  localparam cfg_idx_t REG_GRID_HEIGHT = 2'd1;

  // Unknown/free flag pairs of one cell: bit 0 unknown, bit 1 free.
  typedef logic [1:0] cell_bits_t;
  typedef logic [17:0] window_t;

  // True when any in-window 8-neighbor of window cell (col,row) is free.
  function automatic logic near_free(window_t win, int col, int row);
    logic hit;
    int nc;
    int nr;
    hit = 1'b0;
    for (int dc = -1; dc <= 1; dc++) begin
      for (int dr = -1; dr <= 1; dr++) begin
        nc = col + dc;
        nr = row + dr;
        if (!(dc == 0 && dr == 0) && nc >= 0 && nc <= 2 && nr >= 0 && nr <= 2) begin
          if (win[6 * nc + 2 * nr + 1]) hit = 1'b1;
        end
      end
    end
    return hit;
  endfunction

  function automatic count_t sat_add(count_t base, logic [2:0] inc);
    logic [CNT_W:0] sum;
    sum = {1'b0, base} + {{(CNT_W - 2){1'b0}}, inc};
    return sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
  endfunction

endpackage

// ===== design/grid_frontier_completion_check.sv =====
// Grid frontier completion check: top level with line buffer, window and counters.
// Takes one cost byte per clock in raster order and, on the last cell of a frame,
// produces one word with the sampled, unknown and frontier counts and the completion
// flag. Sustained rate is one cell per cycle; the line buffer is a single memory of
// MAX_WIDTH entries holding both earlier rows, written at the current column and read
// one column ahead, so each accepted cell finds its column data already registered.
// The result word passes through the pending registers before it reaches the output register.
// The input stalls only while a finished frame's word waits behind a stalled output word.
// The buffer needs no clearing pass after reset: rows not yet streamed are masked.
module grid_frontier_completion_check
  import gfcc_pkg::*;
#(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  size_t    cfg_data,
  input  logic     cell_valid,
  output logic     cell_stall,
  input  cost_t    cell_cost,
  output logic     result_valid,
  input  logic     result_stall,
  output logic     exploration_done,
  output count_t   sampled_count,
  output count_t   unknown_count,
  output count_t   frontier_count
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int DW = ((CW > RW ? CW : RW) + 1 > SIZE_W) ? (CW > RW ? CW : RW) + 1 : SIZE_W;

  // configuration
  size_t grid_width;
  size_t grid_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= SIZE_W'(4096);
      grid_height <= SIZE_W'(4096);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_WIDTH: grid_width <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [DW-1:0] w_eff;
  logic [DW-1:0] h_eff;

  always_comb begin
    if (grid_width == '0) w_eff = DW'(1);
    else if (DW'(grid_width) > DW'(MAX_WIDTH)) w_eff = DW'(MAX_WIDTH);
    else w_eff = DW'(grid_width);
    if (grid_height == '0) h_eff = DW'(1);
    else if (DW'(grid_height) > DW'(MAX_HEIGHT)) h_eff = DW'(MAX_HEIGHT);
    else h_eff = DW'(grid_height);
  end

  // frame position
  logic [CW-1:0] column_position;
  logic [RW-1:0] row_position;
  logic [1:0]    col_phase;
  logic [1:0]    row_phase;
  window_t       window_bits;
  count_t        sampled_total;
  count_t        unknown_total;
  count_t        frontier_total;

  logic cell_accept;
  logic last_c;
  logic last_r;
  logic frame_end;

  assign cell_accept = cell_valid && !cell_stall;
  assign last_c = DW'(column_position) >= w_eff - DW'(1);
  assign last_r = DW'(row_position) >= h_eff - DW'(1);
  assign frame_end = last_c && last_r;

  logic [CW-1:0] column_position_next;
  assign column_position_next = last_c ? '0 : column_position + CW'(1);

  // line buffer: [3:2] row before last, [1:0] last row
  logic [3:0] row_mem [MAX_WIDTH];
  logic [3:0] row_rd;
  logic [CW-1:0] rd_addr;
  cell_bits_t nb;
  cell_bits_t mid;
  cell_bits_t top;

  assign nb = {cell_cost < COST_BLOCKED, cell_cost == COST_UNKNOWN};
  assign mid = (row_position != '0) ? row_rd[1:0] : 2'b00;
  assign top = (row_position > RW'(1)) ? row_rd[3:2] : 2'b00;
  assign rd_addr = cell_accept ? column_position_next : column_position;

  always_ff @(posedge clk) begin
    if (cell_accept) row_mem[column_position] <= {mid, nb};
    if (cell_accept && rd_addr == column_position) row_rd <= {mid, nb};
    else row_rd <= row_mem[rd_addr];
  end

  // window and visits
  window_t window_next;
  logic [1:0] col_phase_prev;
  logic [1:0] row_phase_prev;
  logic [3:0] visit_en;
  logic [3:0] visit_unk;
  logic [3:0] visit_fr;
  logic [2:0] inc_s;
  logic [2:0] inc_u;
  logic [2:0] inc_f;

  assign col_phase_prev = (col_phase == 2'd0) ? 2'd2 : col_phase - 2'd1;
  assign row_phase_prev = (row_phase == 2'd0) ? 2'd2 : row_phase - 2'd1;

  always_comb begin
    window_next = {nb, mid, top, (column_position == '0) ? 12'd0 : window_bits[17:6]};
    visit_en[0] = row_position != '0 && column_position != '0 &&
                  row_phase_prev == 2'd0 && col_phase_prev == 2'd0;
    visit_en[1] = row_position != '0 && last_c && row_phase_prev == 2'd0 && col_phase == 2'd0;
    visit_en[2] = last_r && column_position != '0 && row_phase == 2'd0 && col_phase_prev == 2'd0;
    visit_en[3] = last_r && last_c && row_phase == 2'd0 && col_phase == 2'd0;
    visit_unk[0] = window_next[6 * 1 + 2 * 1];
    visit_unk[1] = window_next[6 * 2 + 2 * 1];
    visit_unk[2] = window_next[6 * 1 + 2 * 2];
    visit_unk[3] = window_next[6 * 2 + 2 * 2];
    visit_fr[0] = near_free(window_next, 1, 1);
    visit_fr[1] = near_free(window_next, 2, 1);
    visit_fr[2] = near_free(window_next, 1, 2);
    visit_fr[3] = near_free(window_next, 2, 2);
    inc_s = '0;
    inc_u = '0;
    inc_f = '0;
    for (int k = 0; k < 4; k++) begin
      inc_s = inc_s + {2'b00, visit_en[k]};
      inc_u = inc_u + {2'b00, visit_en[k] & visit_unk[k]};
      inc_f = inc_f + {2'b00, visit_en[k] & visit_unk[k] & visit_fr[k]};
    end
  end

  count_t sampled_next;
  count_t unknown_next;
  count_t frontier_next;

  assign sampled_next = sat_add(sampled_total, inc_s);
  assign unknown_next = sat_add(unknown_total, inc_u);
  assign frontier_next = sat_add(frontier_total, inc_f);

  // pending frame totals and output word
  logic   pend_valid;
  count_t pend_sampled;
  count_t pend_unknown;
  count_t pend_frontier;
  logic   out_load;

  assign out_load = pend_valid && (!result_valid || !result_stall);
  assign cell_stall = pend_valid && !out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position <= '0;
      col_phase <= 2'd0;
      row_phase <= 2'd0;
      window_bits <= '0;
      sampled_total <= '0;
      unknown_total <= '0;
      frontier_total <= '0;
    end else if (cell_accept) begin
      window_bits <= window_next;
      column_position <= column_position_next;
      col_phase <= (last_c || col_phase == 2'd2) ? 2'd0 : col_phase + 2'd1;
      if (last_c) begin
        row_position <= last_r ? '0 : row_position + RW'(1);
        row_phase <= (last_r || row_phase == 2'd2) ? 2'd0 : row_phase + 2'd1;
      end
      if (frame_end) begin
        sampled_total <= '0;
        unknown_total <= '0;
        frontier_total <= '0;
      end else begin
        sampled_total <= sampled_next;
        unknown_total <= unknown_next;
        frontier_total <= frontier_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cell_accept && frame_end) begin
      pend_valid <= 1'b1;
    end else if (out_load) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_accept && frame_end) begin
      pend_sampled <= sampled_next;
      pend_unknown <= unknown_next;
      pend_frontier <= frontier_next;
    end
  end

  logic [CNT_W+4:0] unk_x25;
  logic [CNT_W+4:0] smp_x2;
  logic [CNT_W+7:0] fr_x200;
  logic [CNT_W+7:0] smp_x3;
  logic             done_next;

  assign unk_x25 = (CNT_W + 5)'(pend_unknown) * (CNT_W + 5)'(25);
  assign smp_x2 = (CNT_W + 5)'(pend_sampled) * (CNT_W + 5)'(2);
  assign fr_x200 = (CNT_W + 8)'(pend_frontier) * (CNT_W + 8)'(200);
  assign smp_x3 = (CNT_W + 8)'(pend_sampled) * (CNT_W + 8)'(3);
  assign done_next = (pend_sampled != '0) && ((unk_x25 < smp_x2) || (fr_x200 < smp_x3));

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      exploration_done <= done_next;
      sampled_count <= pend_sampled;
      unknown_count <= pend_unknown;
      frontier_count <= pend_frontier;
    end
  end

`ifndef SYNTHESIS
  a_pend_protected: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !out_load) |-> !cell_accept)
    else $error("pending totals overwritten");

  a_frame_end_pends: assert property (@(posedge clk) disable iff (rst)
    (cell_accept && frame_end) |=> pend_valid)
    else $error("frame end lost");

  a_count_order: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (unknown_count <= sampled_count && frontier_count <= unknown_count))
    else $error("result counts out of order");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the grid frontier completion check: random frames with live prediction.
`timescale 1ns / 1ps

module testbench;
  import gfcc_pkg::*;

  localparam int MAX_W = 4096;
  localparam int MAX_H = 4096;
  localparam int RANDOM_CELLS = 1740;
  localparam longint CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic done;
    count_t sampled;
    count_t unknown;
    count_t frontier;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = REG_GRID_WIDTH;
  size_t cfg_data = '0;
  logic cell_valid = 1'b0;
  logic cell_stall;
  cost_t cell_cost = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic exploration_done;
  count_t sampled_count;
  count_t unknown_count;
  count_t frontier_count;

  grid_frontier_completion_check dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cell_valid(cell_valid),
    .cell_stall(cell_stall),
    .cell_cost(cell_cost),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .exploration_done(exploration_done),
    .sampled_count(sampled_count),
    .unknown_count(unknown_count),
    .frontier_count(frontier_count)
  );

  always #10 clk = ~clk;

  // grid scan predictor state
  size_t grid_w_set;
  size_t grid_h_set;
  cell_bits_t row_flags [0:2*MAX_W-1];
  int unsigned col_pos;
  int unsigned row_pos;
  window_t win;
  count_t n_sampled;
  count_t n_unknown;
  count_t n_frontier;

  report_t frame_reports[$];
  cost_t cell_queue[$];
  report_t seen;
  logic cell_taken = 1'b0;
  logic quiet = 1'b0;
  int cell_gap = 0;
  int stall_left = 0;
  int errors = 0;
  int frames_checked = 0;
  int frames_done = 0;
  int cells_seen = 0;
  int resizes = 0;
  longint cycles = 0;

  function automatic int unsigned eff_size(size_t v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic count_t bump(count_t v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  // judge the window cell (wc,wr) that sits at grid (rr,cc)
  function automatic void tally(int unsigned rr, int unsigned cc, int wc, int wr);
    logic hit;
    hit = 1'b0;
    if (rr % 3 != 0 || cc % 3 != 0) return;
    n_sampled = bump(n_sampled);
    if (!win[6*wc + 2*wr]) return;
    n_unknown = bump(n_unknown);
    for (int x = wc - 1; x <= wc + 1; x++)
      for (int y = wr - 1; y <= wr + 1; y++)
        if ((x != wc || y != wr) && x >= 0 && x <= 2 && y >= 0 && y <= 2 && win[6*x + 2*y + 1])
          hit = 1'b1;
    if (hit) n_frontier = bump(n_frontier);
  endfunction

  function automatic void scan_cell(cost_t cost);
    int unsigned w, h, c, r, idx;
    cell_bits_t nb, top, mid;
    logic last_c, last_r;
    longint unsigned s, u, f;
    report_t rep;
    w = eff_size(grid_w_set, MAX_W);
    h = eff_size(grid_h_set, MAX_H);
    c = col_pos;
    r = row_pos;
    nb = {cost < COST_BLOCKED, cost == COST_UNKNOWN};
    idx = (c < MAX_W) ? c : MAX_W - 1;
    top = (r >= 2) ? row_flags[MAX_W + idx] : 2'b00;
    mid = (r >= 1) ? row_flags[idx] : 2'b00;
    last_c = (c >= w - 1);
    last_r = (r >= h - 1);
    if (c == 0) win = '0;
    win = {nb, mid, top, win[17:6]};
    row_flags[MAX_W + idx] = mid;
    row_flags[idx] = nb;
    if (r >= 1) begin
      if (c >= 1) tally(r - 1, c - 1, 1, 1);
      if (last_c) tally(r - 1, c, 2, 1);
    end
    if (last_r) begin
      if (c >= 1) tally(r, c - 1, 1, 2);
      if (last_c) tally(r, c, 2, 2);
    end
    if (!last_c) begin
      col_pos = c + 1;
      return;
    end
    col_pos = 0;
    if (!last_r) begin
      row_pos = r + 1;
      return;
    end
    row_pos = 0;
    s = n_sampled;
    u = n_unknown;
    f = n_frontier;
    rep.done = (s > 0) && (u * 25 < 2 * s || f * 200 < 3 * s);
    rep.sampled = n_sampled;
    rep.unknown = n_unknown;
    rep.frontier = n_frontier;
    frame_reports.insert(frame_reports.size(), rep);
    n_sampled = '0;
    n_unknown = '0;
    n_frontier = '0;
  endfunction

  // cells still to come before the current frame closes
  function automatic int unsigned cells_left();
    int unsigned w, h, rest;
    w = eff_size(grid_w_set, MAX_W);
    h = eff_size(grid_h_set, MAX_H);
    rest = (col_pos >= w - 1) ? 1 : w - col_pos;
    if (row_pos < h - 1) rest += (h - 1 - row_pos) * w;
    return rest;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(16, 60);
  endfunction

  function automatic cost_t pick_cost(int pu, int po);
    int r;
    r = $urandom_range(0, 99);
    if (r < pu) return COST_UNKNOWN;
    if (r < pu + po) return $urandom_range(0, 1) ? COST_BLOCKED : COST_BLOCKED + 8'd1;
    return cost_t'($urandom_range(0, COST_BLOCKED - 1));
  endfunction

  task automatic queue_cells(int unsigned n, int pu, int po);
    for (int unsigned i = 0; i < n; i++) cell_queue.insert(cell_queue.size(), pick_cost(pu, po));
  endtask

  task automatic write_reg(cfg_idx_t idx, size_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_GRID_WIDTH) grid_w_set = val;
    else grid_h_set = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (cell_queue.size() != 0 || cell_valid || frame_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_frame(size_t w, size_t h, int pu, int po);
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    queue_cells(eff_size(w, MAX_W) * eff_size(h, MAX_H), pu, po);
    settle();
  endtask

  // cell driver
  always @(negedge clk) begin
    if (!rst && !(cell_valid && !cell_taken)) begin
      if (cell_gap > 0) begin
        cell_valid <= 1'b0;
        cell_gap = cell_gap - 1;
      end else if (cell_queue.size() != 0) begin
        cell_valid <= 1'b1;
        cell_cost <= cell_queue.pop_front();
        cell_gap = pick_gap();
      end else begin
        cell_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      result_stall <= 1'b0;
      stall_left = pick_gap();
    end
  end

  // acceptance tracking, prediction and result checking
  always @(posedge clk) begin
    cell_taken = cell_valid && !cell_stall;
    if (!rst) begin
      if (cell_taken) begin
        scan_cell(cell_cost);
        cells_seen++;
      end
      if (result_valid && !result_stall) begin
        if (frame_reports.size() == 0) begin
          $error("result word with no frame pending");
          errors++;
        end else begin
          seen = frame_reports.pop_front();
          frames_checked++;
          if (seen.done) frames_done++;
          if (exploration_done !== seen.done) begin
            $error("exploration_done exp %0d got %0d", seen.done, exploration_done);
            errors++;
          end
          if (sampled_count !== seen.sampled) begin
            $error("sampled_count exp %0d got %0d", seen.sampled, sampled_count);
            errors++;
          end
          if (unknown_count !== seen.unknown) begin
            $error("unknown_count exp %0d got %0d", seen.unknown, unknown_count);
            errors++;
          end
          if (frontier_count !== seen.frontier) begin
            $error("frontier_count exp %0d got %0d", seen.frontier, frontier_count);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    int unsigned w, h, ew, eh, k, start;
    int pu, po;
    int mix [7];
    cost_t grid4 [16];
    mix = '{0, 2, 6, 30, 60, 90, 100};
    grid4 = '{255, 0, 255, 254, 253, 255, 252, 255,
              255, 255, 255, 255, 1, 255, 128, 127};
    grid_w_set = 13'd4096;
    grid_h_set = 13'd4096;
    foreach (row_flags[i]) row_flags[i] = 2'b00;
    col_pos = 0;
    row_pos = 0;
    win = '0;
    n_sampled = '0;
    n_unknown = '0;
    n_frontier = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset-size frame shrunk while row 0 is under way
    cell_queue = '{255, 0, 255, 254, 253, 252};
    settle();
    write_reg(REG_GRID_WIDTH, 13'd3);
    write_reg(REG_GRID_HEIGHT, 13'd2);
    resizes++;
    queue_cells(cells_left(), 50, 10);
    settle();

    // 4x4 frame with hand-picked costs
    write_reg(REG_GRID_WIDTH, 13'd4);
    write_reg(REG_GRID_HEIGHT, 13'd4);
    foreach (grid4[i]) cell_queue.insert(cell_queue.size(), grid4[i]);
    settle();

    // zero sizes read as one
    run_frame(13'd0, 13'd7, 95, 2);
    run_frame(13'd9, 13'd0, 2, 5);

    // oversize sizes, cut back before either limit is reached
    write_reg(REG_GRID_WIDTH, 13'd8191);
    write_reg(REG_GRID_HEIGHT, 13'd8191);
    queue_cells(7, 30, 10);
    settle();
    write_reg(REG_GRID_WIDTH, 13'd5);
    write_reg(REG_GRID_HEIGHT, 13'd3);
    resizes++;
    queue_cells(cells_left(), 30, 10);
    settle();

    start = cells_seen;
    while (cells_seen - start < RANDOM_CELLS) begin
      k = $urandom_range(0, 99);
      if (k < 85) begin
        w = $urandom_range(1, 10);
        h = $urandom_range(1, 10);
      end else if (k < 95) begin
        w = $urandom_range(11, 40);
        h = $urandom_range(1, 6);
      end else begin
        w = $urandom_range(0, 2);
        h = $urandom_range(0, 12);
      end
      quiet = ($urandom_range(0, 4) == 0);
      pu = mix[$urandom_range(0, 6)];
      po = $urandom_range(0, 15);
      write_reg(REG_GRID_WIDTH, size_t'(w));
      write_reg(REG_GRID_HEIGHT, size_t'(h));
      ew = eff_size(size_t'(w), MAX_W);
      eh = eff_size(size_t'(h), MAX_H);
      if ($urandom_range(0, 7) == 0 && ew * eh > 2) begin
        // pause mid-frame, then rewrite the width (at most the old one) and the height
        queue_cells($urandom_range(1, ew * eh - 1), pu, po);
        settle();
        write_reg(REG_GRID_WIDTH, size_t'($urandom_range(0, ew)));
        write_reg(REG_GRID_HEIGHT, size_t'($urandom_range(0, eh + 3)));
        resizes++;
        queue_cells(cells_left(), pu, po);
      end else begin
        queue_cells(ew * eh, pu, po);
      end
      settle();
    end
    quiet = 1'b0;
    settle();

    $display("covered %0d cells over %0d frames (%0d flagged done), %0d mid-frame resizes",
             cells_seen, frames_checked, frames_done, resizes);
    $display("sizes from 0 to 8191 written, random idle and back-pressure on both sides");
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
